// ----- hdl/gcu_pkg.sv -----
// Shared constants, types and column scaling function for the glyph column upscaler.
package gcu_pkg;

  localparam int ColumnBytes = 2;
  localparam int ColumnBits  = ColumnBytes * 8;
  localparam int MaxScale    = 4;
  localparam int OutBits     = 64;
  localparam int FactorBits  = 3;
  localparam int GutterBits  = 2;
  localparam int GutCntBits  = 4;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 3;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CFG_SCALE  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_GUTTER = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_SMOOTH = 2'd2;

  typedef struct packed {
    logic [OutBits-1:0] column;
    logic               is_gutter;
    logic               last;
  } beat_t;

  // Clamp the raw factor register into 1..MaxScale.
  function automatic logic [FactorBits-1:0] eff_factor(input logic [FactorBits-1:0] raw);
    logic [FactorBits-1:0] f;
    f = raw;
    if (raw == '0) begin
      f = FactorBits'(1);
    end else if (raw > FactorBits'(MaxScale)) begin
      f = FactorBits'(MaxScale);
    end
    return f;
  endfunction

  // Replicate each column bit f times vertically; upper bits stay zero.
  function automatic logic [OutBits-1:0] scale_column(input logic [ColumnBits-1:0] col,
                                                      input logic [FactorBits-1:0] f);
    logic [OutBits-1:0] res;
    res = '0;
    case (f)
      3'd2: begin
        for (int j = 0; j < ColumnBits; j++) res[2*j +: 2] = {2{col[j]}};
      end
      3'd3: begin
        for (int j = 0; j < ColumnBits; j++) res[3*j +: 3] = {3{col[j]}};
      end
      3'd4: begin
        for (int j = 0; j < ColumnBits; j++) res[4*j +: 4] = {4{col[j]}};
      end
      default: begin
        res[ColumnBits-1:0] = col;
      end
    endcase
    return res;
  endfunction

endpackage

// ----- hdl/gcu_seq.sv -----
// Holding slot and beat sequencer: gutter beats first, then the column copies.
module gcu_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  logic [gcu_pkg::OutBits-1:0]         first_col_i,
  input  logic [gcu_pkg::OutBits-1:0]         scaled_col_i,
  input  logic [gcu_pkg::GutCntBits-1:0]      gut_cnt_i,
  input  logic [gcu_pkg::FactorBits-1:0]      copies_i,
  input  logic                                take_i,
  output logic                                valid_o,
  output logic                                done_o,
  output gcu_pkg::beat_t                      beat_o
);
  import gcu_pkg::*;

  logic                  valid_q, valid_d;
  logic                  first_q, first_d;
  logic [GutCntBits-1:0] gut_q, gut_d;
  logic [FactorBits-1:0] copy_q, copy_d;
  logic [OutBits-1:0]    first_col_q, scaled_q;

  logic in_gutter;
  logic last_copy;

  assign in_gutter = (gut_q != '0);
  assign last_copy = (copy_q == FactorBits'(1));

  always_comb begin
    beat_o.is_gutter = in_gutter;
    beat_o.last      = !in_gutter && last_copy;
    if (in_gutter) begin
      beat_o.column = '0;
    end else if (first_q) begin
      beat_o.column = first_col_q;
    end else begin
      beat_o.column = scaled_q;
    end
  end

  assign valid_o = valid_q;
  assign done_o  = valid_q && take_i && !in_gutter && last_copy;

  always_comb begin
    valid_d = valid_q;
    first_d = first_q;
    gut_d   = gut_q;
    copy_d  = copy_q;
    if (load_i) begin
      valid_d = 1'b1;
      first_d = 1'b1;
      gut_d   = gut_cnt_i;
      copy_d  = copies_i;
    end else if (valid_q && take_i) begin
      if (in_gutter) begin
        gut_d = gut_q - GutCntBits'(1);
      end else begin
        first_d = 1'b0;
        copy_d  = copy_q - FactorBits'(1);
        if (last_copy) begin
          valid_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      first_q <= 1'b0;
      gut_q   <= '0;
      copy_q  <= '0;
    end else begin
      valid_q <= valid_d;
      first_q <= first_d;
      gut_q   <= gut_d;
      copy_q  <= copy_d;
    end
  end

  // Payload: load with the item
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      first_col_q <= first_col_i;
      scaled_q    <= scaled_col_i;
    end
  end

endmodule

// ----- hdl/glyph_column_upscaler.sv -----
// Top level of the glyph column upscaler: config, column scaling and output register.
//
// Each accepted 16-pixel font column is scaled by the clamped factor f (1..4): every pixel
// is repeated f times down the column, giving 16*f used bits of column_out_o with the rest
// zero, and the column is sent f times across. With smoothing on, the first copy is ORed
// with the previous unsmoothed scaled column; that history is cleared by glyph_start_i.
// An item with gutter_before_i set is preceded by gutter_columns*f blank beats flagged
// is_gutter_o. last_out_o marks the final beat of each item. An item produces f output
// beats, plus gutter_columns*f blank beats when gutter_before_i is set, one per cycle while
// out_ready_i is high. Scaling is done at accept time into a one-item holding slot, and
// the next item is taken in the same cycle that the last beat of the held one moves to
// the output register, so items flow back to back with no bubble. Configuration writes
// are registered; index 3 is ignored.
module glyph_column_upscaler (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [gcu_pkg::CfgIdxBits-1:0]       cfg_idx_i,
  input  logic [gcu_pkg::CfgDataBits-1:0]      cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [gcu_pkg::ColumnBits-1:0]       column_in_i,
  input  logic                                 glyph_start_i,
  input  logic                                 gutter_before_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [gcu_pkg::OutBits-1:0]          column_out_o,
  output logic                                 is_gutter_o,
  output logic                                 last_out_o
);
  import gcu_pkg::*;

  // Configuration registers
  logic [FactorBits-1:0] scale_q;
  logic [GutterBits-1:0] gutter_q;
  logic                  smooth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= FactorBits'(1);
      gutter_q <= GutterBits'(1);
      smooth_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCALE:  scale_q  <= cfg_data_i;
        CFG_GUTTER: gutter_q <= cfg_data_i[GutterBits-1:0];
        CFG_SMOOTH: smooth_q <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  // Scale the incoming column at accept time
  logic [FactorBits-1:0] factor;
  logic [OutBits-1:0]    scaled;
  logic [OutBits-1:0]    history;
  logic [OutBits-1:0]    first_col;
  logic [GutCntBits-1:0] gut_cnt;
  logic [OutBits-1:0]    prev_q;
  logic                  in_fire;

  assign factor    = eff_factor(scale_q);
  assign scaled    = scale_column(column_in_i, factor);
  assign history   = glyph_start_i ? '0 : prev_q;
  assign first_col = smooth_q ? (scaled | history) : scaled;
  assign gut_cnt   = gutter_before_i
                   ? (GutCntBits'({2'b00, gutter_q}) * GutCntBits'({1'b0, factor}))
                   : '0;
  assign in_fire   = in_valid_i && in_ready_o;

  // History of the last unsmoothed glyph column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (in_fire) begin
      prev_q <= scaled;
    end
  end

  // Holding slot and beat sequencer
  logic  seq_valid;
  logic  seq_done;
  logic  out_free;
  beat_t beat;

  assign out_free   = !out_valid_o || out_ready_i;
  assign in_ready_o = !seq_valid || seq_done;

  gcu_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_fire),
    .first_col_i  (first_col),
    .scaled_col_i (scaled),
    .gut_cnt_i    (gut_cnt),
    .copies_i     (factor),
    .take_i       (out_free),
    .valid_o      (seq_valid),
    .done_o       (seq_done),
    .beat_o       (beat)
  );

  // Output register: advance a beat whenever the slot downstream is free
  logic  out_valid_q;
  beat_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= seq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && seq_valid) begin
      out_q <= beat;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign column_out_o = out_q.column;
  assign is_gutter_o  = out_q.is_gutter;
  assign last_out_o   = out_q.last;

  // A new item only enters while the held one hands over its last beat
  a_accept_on_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && seq_valid) |-> seq_done)
    else $error("item accepted while held item still has beats");

  // An accepted item is held on the next cycle
  a_accept_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> seq_valid)
    else $error("accepted item not held");

  // Gutter beats are blank and never close an item
  a_gutter_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_gutter_o) |-> (column_out_o == '0 && !last_out_o))
    else $error("gutter beat not blank or marked last");

  // Upper bits stay clear at factor one
  a_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && factor == FactorBits'(1)) |-> (column_out_o[OutBits-1:ColumnBits] == '0))
    else $error("bits above the scaled column set");

endmodule
